@@ rtl/core/plsa_em_pkg.sv @@
// Shared types and constants of the PLSA EM iteration core.
// Holds the beat payload structs, command codes, states and control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plsa_em_pkg;

    // Command codes carried in the func field of an input beat.
    typedef enum logic [2:0] {
        FUNC_LOAD     = 3'd0,
        FUNC_WR_PRIOR = 3'd1,
        FUNC_WR_DOC   = 3'd2,
        FUNC_WR_WORD  = 3'd3,
        FUNC_RUN      = 3'd4,
        FUNC_RD_PRIOR = 3'd5,
        FUNC_RD_DOC   = 3'd6,
        FUNC_RD_WORD  = 3'd7
    } func_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NUM_DOCS    = 2'd0;
    localparam logic [1:0] CFG_NUM_WORDS   = 2'd1;
    localparam logic [1:0] CFG_NUM_TOPICS  = 2'd2;
    localparam logic [1:0] CFG_NUM_ENTRIES = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [8:0]  NUM_DOCS_RST    = 9'd256;
    localparam logic [10:0] NUM_WORDS_RST   = 11'd1024;
    localparam logic [4:0]  NUM_TOPICS_RST  = 5'd16;
    localparam logic [12:0] NUM_ENTRIES_RST = 13'd0;

    localparam int ACC_W   = 56;
    localparam int TOTAL_W = 64;
    localparam int NP_W    = 40;

    typedef struct packed {
        logic [2:0]  func;
        logic [11:0] entry_slot;
        logic [7:0]  doc_index;
        logic [9:0]  word_index;
        logic [15:0] occurrences;
        logic [3:0]  topic_index;
        logic [31:0] prob_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        zero_mass_flag;
    } out_item_t;

    // Operand selection of the shared fraction divider.
    typedef enum logic [1:0] {
        DIV_POST  = 2'd0,
        DIV_DOC   = 2'd1,
        DIV_WORD  = 2'd2,
        DIV_PRIOR = 2'd3
    } div_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RESP,
        S_CLEAR,
        S_ENT,
        S_ENT_CHK,
        S_P_RD,
        S_P_MUL1,
        S_P_MUL2,
        S_P_ACC,
        S_Q_RD,
        S_Q_DIV,
        S_Q_WAIT,
        S_Q_WR,
        S_T_RD,
        S_T_ADD,
        S_N_Z,
        S_N_MASS,
        S_N_DRD,
        S_N_DDIV,
        S_N_DWAIT,
        S_N_WRD,
        S_N_WDIV,
        S_N_WWAIT,
        S_N_PDIV,
        S_N_PWAIT
    } state_t;

    typedef struct packed {
        logic     host_accept;
        logic     run_start;
        logic     run_active;
        logic     clr_step;
        logic     e_inc;
        logic     z_clr;
        logic     z_inc;
        logic     i_clr;
        logic     i_inc;
        logic     sum_clr;
        logic     mul1;
        logic     mul2;
        logic     prod_wr;
        logic     div_start;
        div_sel_t div_sel;
        logic     np_mul;
        logic     acc_wr;
        logic     total_clr;
        logic     total_add;
        logic     mass_ld;
        logic     norm;
        logic     doc_wr;
        logic     word_wr;
        logic     prior_wr;
        logic     flag_set;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_is_run;
        logic out_free;
        logic clr_last;
        logic e_done;
        logic ent_ok;
        logic z_done;
        logic i_doc_done;
        logic i_word_done;
        logic sum_zero;
        logic mass_zero;
        logic div_done;
    } ctrl_status_t;

endpackage

`default_nettype wire

@@ rtl/core/plsa_em_iteration_core.sv @@
// Top level of the PLSA expectation-maximization iteration core.
// Instantiates plsa_em_ctrl and plsa_em_dpath; depends on plsa_em_pkg.
//
// Host beats load corpus entries, write and read the prior, doc-topic and
// word-topic tables (Q0.32), and start one EM iteration. Each beat gives one
// result beat: read data for reads, the zero-mass flag for a run, zeros
// otherwise. Loads, writes and reads pass from the command state through the
// response state into the result register. A run first clears the
// accumulators in a sweep over max(MAX_DOCS, MAX_WORDS, 1) * MAX_TOPICS
// addresses, then for each entry forms the per-topic products and the
// posterior divide and accumulate, then renormalizes each table entry with
// the 32-step shared divider; a zero divisor or a saturating quotient ends
// a divide without stepping. Configuration is written only while the core
// is idle; the user must keep to this, as the core does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module plsa_em_iteration_core #(
    parameter int MAX_DOCS    = 256,
    parameter int MAX_WORDS   = 1024,
    parameter int MAX_TOPICS  = 16,
    parameter int MAX_ENTRIES = 4096
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire plsa_em_pkg::in_item_t              in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output plsa_em_pkg::out_item_t                  out_data,
    input  wire logic                               cfg_we,
    input  wire logic [plsa_em_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [plsa_em_pkg::CFG_DATA_W-1:0] cfg_data
);
    import plsa_em_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    plsa_em_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    plsa_em_dpath #(
        .MAX_DOCS    (MAX_DOCS),
        .MAX_WORDS   (MAX_WORDS),
        .MAX_TOPICS  (MAX_TOPICS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ rtl/core/plsa_em_div.sv @@
// Restoring fraction divider: floor(num * 2^32 / den), saturated to Q0.32.
// One quotient bit per cycle. Depends on plsa_em_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plsa_em_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [plsa_em_pkg::ACC_W-1:0]   num,
    input  wire logic [plsa_em_pkg::TOTAL_W-1:0] den,
    output logic                                 done,
    output logic [31:0]                          quot
);
    import plsa_em_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [TOTAL_W-1:0] rem_reg, rem_next;
    logic [TOTAL_W-1:0] den_reg, den_next;
    logic [31:0]        quot_reg, quot_next;
    logic [TOTAL_W:0]   shifted;
    logic [TOTAL_W:0]   diff;

    // One shift-and-subtract step.
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            if (den == '0)
            begin
                quot_next = '0;
                done_next = 1'b1;
            end
            else if (TOTAL_W'(num) >= den)
            begin
                quot_next = '1;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = TOTAL_W'(num);
                den_next  = den;
                quot_next = '0;
                cnt_next  = 5'd31;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!diff[TOTAL_W])
            begin
                rem_next  = diff[TOTAL_W-1:0];
                quot_next = {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[TOTAL_W-1:0];
                quot_next = {quot_reg[30:0], 1'b0};
            end
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

@@ rtl/core/plsa_em_ctrl.sv @@
// Sequencer of the PLSA EM iteration core: host beats and the run phases.
// Drives datapath commands from datapath status. Depends on plsa_em_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plsa_em_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire plsa_em_pkg::ctrl_status_t status,
    output plsa_em_pkg::ctrl_cmd_t         cmd
);
    import plsa_em_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.in_is_run ? S_CLEAR : S_RESP;
                end
            end
            S_RESP:    if (status.out_free) state_next = S_IDLE;
            S_CLEAR:   if (status.clr_last) state_next = S_ENT;
            S_ENT:     state_next = status.e_done ? S_T_RD : S_ENT_CHK;
            S_ENT_CHK: state_next = status.ent_ok ? S_P_RD : S_ENT;
            S_P_RD:
            begin
                if (!status.z_done)
                begin
                    state_next = S_P_MUL1;
                end
                else
                begin
                    state_next = status.sum_zero ? S_ENT : S_Q_RD;
                end
            end
            S_P_MUL1:  state_next = S_P_MUL2;
            S_P_MUL2:  state_next = S_P_ACC;
            S_P_ACC:   state_next = S_P_RD;
            S_Q_RD:    state_next = status.z_done ? S_ENT : S_Q_DIV;
            S_Q_DIV:   state_next = S_Q_WAIT;
            S_Q_WAIT:  if (status.div_done) state_next = S_Q_WR;
            S_Q_WR:    state_next = S_Q_RD;
            S_T_RD:    state_next = status.z_done ? S_N_Z : S_T_ADD;
            S_T_ADD:   state_next = S_T_RD;
            S_N_Z:     state_next = status.z_done ? S_RESP : S_N_MASS;
            S_N_MASS:  state_next = S_N_DRD;
            S_N_DRD:   state_next = status.i_doc_done ? S_N_WRD : S_N_DDIV;
            S_N_DDIV:  state_next = S_N_DWAIT;
            S_N_DWAIT: if (status.div_done) state_next = S_N_DRD;
            S_N_WRD:   state_next = status.i_word_done ? S_N_PDIV : S_N_WDIV;
            S_N_WDIV:  state_next = S_N_WWAIT;
            S_N_WWAIT: if (status.div_done) state_next = S_N_WRD;
            S_N_PDIV:  state_next = S_N_PWAIT;
            S_N_PWAIT: if (status.div_done) state_next = S_N_Z;
            default:   state_next = S_IDLE;
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd            = '0;
        cmd.div_sel    = DIV_POST;
        cmd.run_active = (state_reg != S_IDLE) && (state_reg != S_RESP);
        in_stall       = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.host_accept = in_valid;
                cmd.run_start   = in_valid && status.in_is_run;
            end
            S_RESP:    cmd.out_load = status.out_free;
            S_CLEAR:   cmd.clr_step = 1'b1;
            S_ENT:
            begin
                cmd.z_clr     = status.e_done;
                cmd.total_clr = status.e_done;
            end
            S_ENT_CHK:
            begin
                cmd.z_clr   = status.ent_ok;
                cmd.sum_clr = status.ent_ok;
                cmd.e_inc   = !status.ent_ok;
            end
            S_P_RD:
            begin
                if (status.z_done)
                begin
                    cmd.flag_set = status.sum_zero;
                    cmd.e_inc    = status.sum_zero;
                    cmd.z_clr    = !status.sum_zero;
                end
            end
            S_P_MUL1:  cmd.mul1 = 1'b1;
            S_P_MUL2:  cmd.mul2 = 1'b1;
            S_P_ACC:
            begin
                cmd.prod_wr = 1'b1;
                cmd.z_inc   = 1'b1;
            end
            S_Q_RD:    cmd.e_inc = status.z_done;
            S_Q_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_POST;
            end
            S_Q_WAIT:  cmd.np_mul = status.div_done;
            S_Q_WR:
            begin
                cmd.acc_wr = 1'b1;
                cmd.z_inc  = 1'b1;
            end
            S_T_RD:    cmd.z_clr = status.z_done;
            S_T_ADD:
            begin
                cmd.total_add = 1'b1;
                cmd.z_inc     = 1'b1;
            end
            S_N_Z:     cmd.norm = 1'b1;
            S_N_MASS:
            begin
                cmd.norm    = 1'b1;
                cmd.mass_ld = 1'b1;
                cmd.i_clr   = 1'b1;
            end
            S_N_DRD:
            begin
                cmd.norm     = 1'b1;
                cmd.flag_set = status.mass_zero;
                cmd.i_clr    = status.i_doc_done;
            end
            S_N_DDIV:
            begin
                cmd.norm      = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DOC;
            end
            S_N_DWAIT:
            begin
                cmd.norm   = 1'b1;
                cmd.doc_wr = status.div_done;
                cmd.i_inc  = status.div_done;
            end
            S_N_WRD:   cmd.norm = 1'b1;
            S_N_WDIV:
            begin
                cmd.norm      = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_WORD;
            end
            S_N_WWAIT:
            begin
                cmd.norm    = 1'b1;
                cmd.word_wr = status.div_done;
                cmd.i_inc   = status.div_done;
            end
            S_N_PDIV:
            begin
                cmd.norm      = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PRIOR;
            end
            S_N_PWAIT:
            begin
                cmd.norm     = 1'b1;
                cmd.prior_wr = status.div_done;
                cmd.z_inc    = status.div_done;
            end
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/plsa_em_dpath.sv @@
// Datapath of the PLSA EM iteration core: tables, accumulators, loop counters,
// multipliers, the shared divider and the output register.
// Depends on plsa_em_pkg and plsa_em_div.
`timescale 1ns / 1ps
`default_nettype none

module plsa_em_dpath #(
    parameter int MAX_DOCS    = 256,
    parameter int MAX_WORDS   = 1024,
    parameter int MAX_TOPICS  = 16,
    parameter int MAX_ENTRIES = 4096
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire plsa_em_pkg::in_item_t                   in_data,
    input  wire logic                                    cfg_we,
    input  wire logic [plsa_em_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [plsa_em_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire plsa_em_pkg::ctrl_cmd_t                  cmd,
    output plsa_em_pkg::ctrl_status_t                    status,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output plsa_em_pkg::out_item_t                       out_data
);
    import plsa_em_pkg::*;

    localparam int DOC_DEPTH  = MAX_DOCS * MAX_TOPICS;
    localparam int WORD_DEPTH = MAX_WORDS * MAX_TOPICS;
    localparam int EAW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EW   = $clog2(MAX_ENTRIES + 1);
    localparam int ZAW  = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1;
    localparam int ZW   = $clog2(MAX_TOPICS + 1);
    localparam int NDW  = $clog2(MAX_DOCS + 1);
    localparam int NWW  = $clog2(MAX_WORDS + 1);
    localparam int IMAX = (MAX_DOCS > MAX_WORDS) ? MAX_DOCS : MAX_WORDS;
    localparam int IW   = $clog2(IMAX + 1);
    localparam int DAW  = (DOC_DEPTH > 1) ? $clog2(DOC_DEPTH) : 1;
    localparam int WAW  = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
    localparam int CLR_A = (DOC_DEPTH > WORD_DEPTH) ? DOC_DEPTH : WORD_DEPTH;
    localparam int CLR_N = (CLR_A > MAX_TOPICS) ? CLR_A : MAX_TOPICS;
    localparam int CW   = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int SUMW = 32 + ZW;

    // Configuration registers.
    logic [8:0]  num_docs_reg;
    logic [10:0] num_words_reg;
    logic [4:0]  num_topics_reg;
    logic [12:0] num_entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_docs_reg    <= NUM_DOCS_RST;
            num_words_reg   <= NUM_WORDS_RST;
            num_topics_reg  <= NUM_TOPICS_RST;
            num_entries_reg <= NUM_ENTRIES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_DOCS:    num_docs_reg    <= cfg_data[8:0];
                CFG_NUM_WORDS:   num_words_reg   <= cfg_data[10:0];
                CFG_NUM_TOPICS:  num_topics_reg  <= cfg_data[4:0];
                CFG_NUM_ENTRIES: num_entries_reg <= cfg_data[12:0];
                default:         num_docs_reg    <= num_docs_reg;
            endcase
        end
    end

    // Sizes in use, limited to the store sizes.
    logic [NDW-1:0] nd;
    logic [NWW-1:0] nw;
    logic [ZW-1:0]  nz;
    logic [EW-1:0]  ne;

    assign nd = (32'(num_docs_reg) < MAX_DOCS) ? NDW'(num_docs_reg) : NDW'(MAX_DOCS);
    assign nw = (32'(num_words_reg) < MAX_WORDS) ? NWW'(num_words_reg) : NWW'(MAX_WORDS);
    assign nz = (32'(num_topics_reg) < MAX_TOPICS) ? ZW'(num_topics_reg) : ZW'(MAX_TOPICS);
    assign ne = (32'(num_entries_reg) < MAX_ENTRIES) ? EW'(num_entries_reg)
                                                      : EW'(MAX_ENTRIES);

    // Loop counters.
    logic [CW-1:0] c_reg;
    logic [EW-1:0] e_reg;
    logic [ZW-1:0] z_reg;
    logic [IW-1:0] i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= '0;
            e_reg <= '0;
            z_reg <= '0;
            i_reg <= '0;
        end
        else
        begin
            if (cmd.run_start)
                c_reg <= '0;
            else if (cmd.clr_step)
                c_reg <= c_reg + CW'(1);
            if (cmd.run_start)
                e_reg <= '0;
            else if (cmd.e_inc)
                e_reg <= e_reg + EW'(1);
            if (cmd.z_clr)
                z_reg <= '0;
            else if (cmd.z_inc)
                z_reg <= z_reg + ZW'(1);
            if (cmd.i_clr)
                i_reg <= '0;
            else if (cmd.i_inc)
                i_reg <= i_reg + IW'(1);
        end
    end

    // Host beat decode and latched read selection.
    logic  host_zok, host_dok, host_wok;
    func_t func_reg;
    logic  rd_ok_reg;
    func_t in_func;

    assign in_func  = func_t'(in_data.func);
    assign host_zok = 32'(in_data.topic_index) < MAX_TOPICS;
    assign host_dok = host_zok && (32'(in_data.doc_index) < MAX_DOCS);
    assign host_wok = host_zok && (32'(in_data.word_index) < MAX_WORDS);

    always_ff @(posedge clk)
    begin
        if (cmd.host_accept)
        begin
            func_reg <= in_func;
            case (in_func)
                FUNC_RD_PRIOR: rd_ok_reg <= host_zok;
                FUNC_RD_DOC:   rd_ok_reg <= host_dok;
                FUNC_RD_WORD:  rd_ok_reg <= host_wok;
                default:       rd_ok_reg <= 1'b0;
            endcase
        end
    end

    // Addresses.
    logic [31:0]    ent_doc, ent_word;
    logic [15:0]    ent_cnt;
    logic [33:0]    corpus_rd_reg;
    logic [ZAW-1:0] z_addr;
    logic [DAW-1:0] host_doc_addr, run_doc_addr;
    logic [WAW-1:0] host_word_addr, run_word_addr;
    logic [31:0]    doc_row, word_row;

    assign ent_doc  = 32'(corpus_rd_reg[33:26]);
    assign ent_word = 32'(corpus_rd_reg[25:16]);
    assign ent_cnt  = corpus_rd_reg[15:0];
    assign z_addr   = z_reg[ZAW-1:0];
    assign doc_row  = cmd.norm ? 32'(i_reg) : ent_doc;
    assign word_row = cmd.norm ? 32'(i_reg) : ent_word;

    assign host_doc_addr  = DAW'(32'(in_data.doc_index) * MAX_TOPICS
                                + 32'(in_data.topic_index));
    assign host_word_addr = WAW'(32'(in_data.word_index) * MAX_TOPICS
                                + 32'(in_data.topic_index));
    assign run_doc_addr   = DAW'(doc_row * MAX_TOPICS + 32'(z_reg));
    assign run_word_addr  = WAW'(word_row * MAX_TOPICS + 32'(z_reg));

    logic rd_en;
    assign rd_en = cmd.host_accept || cmd.run_active;

    // Divider and its operand selection.
    logic [ACC_W-1:0]   div_num;
    logic [TOTAL_W-1:0] div_den;
    logic               div_done;
    logic [31:0]        div_quot;
    logic [31:0]        prod_rd_reg;
    logic [SUMW-1:0]    sum_reg;
    logic [ACC_W-1:0]   doc_acc_rd_reg, word_acc_rd_reg, topic_acc_rd_reg;
    logic [ACC_W-1:0]   mass_reg;
    logic [TOTAL_W-1:0] total_reg;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_POST:
            begin
                div_num = ACC_W'(prod_rd_reg);
                div_den = TOTAL_W'(sum_reg);
            end
            DIV_DOC:
            begin
                div_num = doc_acc_rd_reg;
                div_den = TOTAL_W'(mass_reg);
            end
            DIV_WORD:
            begin
                div_num = word_acc_rd_reg;
                div_den = TOTAL_W'(mass_reg);
            end
            DIV_PRIOR:
            begin
                div_num = mass_reg;
                div_den = total_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    plsa_em_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Corpus store.
    logic [33:0] corpus_mem [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (cmd.host_accept && (in_func == FUNC_LOAD)
            && (32'(in_data.entry_slot) < MAX_ENTRIES))
        begin
            corpus_mem[EAW'(in_data.entry_slot)] <= {in_data.doc_index,
                                                     in_data.word_index,
                                                     in_data.occurrences};
        end
        if (rd_en)
        begin
            corpus_rd_reg <= corpus_mem[e_reg[EAW-1:0]];
        end
    end

    // Topic prior table.
    logic [31:0]    prior_mem [MAX_TOPICS];
    logic [31:0]    prior_rd_reg;
    logic           prior_we;
    logic [ZAW-1:0] prior_wa, prior_ra;
    logic [31:0]    prior_wd;

    assign prior_we = (cmd.host_accept && (in_func == FUNC_WR_PRIOR) && host_zok)
                      || cmd.prior_wr;
    assign prior_wa = cmd.prior_wr ? z_addr : ZAW'(in_data.topic_index);
    assign prior_wd = cmd.prior_wr ? div_quot : in_data.prob_value;
    assign prior_ra = cmd.run_active ? z_addr : ZAW'(in_data.topic_index);

    always_ff @(posedge clk)
    begin
        if (prior_we)
            prior_mem[prior_wa] <= prior_wd;
        if (rd_en)
            prior_rd_reg <= prior_mem[prior_ra];
    end

    // Doc-topic table.
    logic [31:0]    doc_mem [DOC_DEPTH];
    logic [31:0]    doc_rd_reg;
    logic           doc_we;
    logic [DAW-1:0] doc_wa, doc_ra;
    logic [31:0]    doc_wd;

    assign doc_we = (cmd.host_accept && (in_func == FUNC_WR_DOC) && host_dok) || cmd.doc_wr;
    assign doc_wa = cmd.doc_wr ? run_doc_addr : host_doc_addr;
    assign doc_wd = cmd.doc_wr ? div_quot : in_data.prob_value;
    assign doc_ra = cmd.run_active ? run_doc_addr : host_doc_addr;

    always_ff @(posedge clk)
    begin
        if (doc_we)
            doc_mem[doc_wa] <= doc_wd;
        if (rd_en)
            doc_rd_reg <= doc_mem[doc_ra];
    end

    // Word-topic table.
    logic [31:0]    word_mem [WORD_DEPTH];
    logic [31:0]    word_rd_reg;
    logic           word_we;
    logic [WAW-1:0] word_wa, word_ra;
    logic [31:0]    word_wd;

    assign word_we = (cmd.host_accept && (in_func == FUNC_WR_WORD) && host_wok)
                     || cmd.word_wr;
    assign word_wa = cmd.word_wr ? run_word_addr : host_word_addr;
    assign word_wd = cmd.word_wr ? div_quot : in_data.prob_value;
    assign word_ra = cmd.run_active ? run_word_addr : host_word_addr;

    always_ff @(posedge clk)
    begin
        if (word_we)
            word_mem[word_wa] <= word_wd;
        if (rd_en)
            word_rd_reg <= word_mem[word_ra];
    end

    // Per-topic products of the current entry.
    logic [31:0] prod_mem [MAX_TOPICS];
    logic [31:0] m1_reg, p_reg;
    logic [63:0] mul1_full, mul2_full;

    assign mul1_full = 64'(prior_rd_reg) * 64'(doc_rd_reg);
    assign mul2_full = 64'(m1_reg) * 64'(word_rd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
            m1_reg <= mul1_full[63:32];
        if (cmd.mul2)
            p_reg <= mul2_full[63:32];
        if (cmd.prod_wr)
            prod_mem[z_addr] <= p_reg;
        if (rd_en)
            prod_rd_reg <= prod_mem[z_addr];
        if (cmd.sum_clr)
            sum_reg <= '0;
        else if (cmd.prod_wr)
            sum_reg <= sum_reg + SUMW'(p_reg);
    end

    // Count-weighted posterior.
    logic [NP_W-1:0] np_reg;
    logic [47:0]     np_full;

    assign np_full = 48'(ent_cnt) * 48'(div_quot);

    always_ff @(posedge clk)
    begin
        if (cmd.np_mul)
            np_reg <= np_full[47:8];
    end

    // Saturating accumulator updates.
    logic [ACC_W:0]   doc_sum, word_sum, topic_sum;
    logic [ACC_W-1:0] doc_acc_wd, word_acc_wd, topic_acc_wd;

    assign doc_sum   = {1'b0, doc_acc_rd_reg} + (ACC_W + 1)'(np_reg);
    assign word_sum  = {1'b0, word_acc_rd_reg} + (ACC_W + 1)'(np_reg);
    assign topic_sum = {1'b0, topic_acc_rd_reg} + (ACC_W + 1)'(np_reg);

    assign doc_acc_wd   = cmd.clr_step ? '0 : (doc_sum[ACC_W] ? '1 : doc_sum[ACC_W-1:0]);
    assign word_acc_wd  = cmd.clr_step ? '0 : (word_sum[ACC_W] ? '1 : word_sum[ACC_W-1:0]);
    assign topic_acc_wd = cmd.clr_step ? '0
                          : (topic_sum[ACC_W] ? '1 : topic_sum[ACC_W-1:0]);

    // Accumulator stores; the clearing sweep writes zeros.
    logic [ACC_W-1:0] doc_acc_mem   [DOC_DEPTH];
    logic [ACC_W-1:0] word_acc_mem  [WORD_DEPTH];
    logic [ACC_W-1:0] topic_acc_mem [MAX_TOPICS];
    logic [DAW-1:0]   doc_acc_wa;
    logic [WAW-1:0]   word_acc_wa;
    logic [ZAW-1:0]   topic_acc_wa;
    logic             doc_acc_we, word_acc_we, topic_acc_we;

    assign doc_acc_we   = (cmd.clr_step && (32'(c_reg) < DOC_DEPTH)) || cmd.acc_wr;
    assign word_acc_we  = (cmd.clr_step && (32'(c_reg) < WORD_DEPTH)) || cmd.acc_wr;
    assign topic_acc_we = (cmd.clr_step && (32'(c_reg) < MAX_TOPICS)) || cmd.acc_wr;
    assign doc_acc_wa   = cmd.clr_step ? DAW'(c_reg) : run_doc_addr;
    assign word_acc_wa  = cmd.clr_step ? WAW'(c_reg) : run_word_addr;
    assign topic_acc_wa = cmd.clr_step ? ZAW'(c_reg) : z_addr;

    always_ff @(posedge clk)
    begin
        if (doc_acc_we)
            doc_acc_mem[doc_acc_wa] <= doc_acc_wd;
        if (rd_en)
            doc_acc_rd_reg <= doc_acc_mem[run_doc_addr];
    end

    always_ff @(posedge clk)
    begin
        if (word_acc_we)
            word_acc_mem[word_acc_wa] <= word_acc_wd;
        if (rd_en)
            word_acc_rd_reg <= word_acc_mem[run_word_addr];
    end

    always_ff @(posedge clk)
    begin
        if (topic_acc_we)
            topic_acc_mem[topic_acc_wa] <= topic_acc_wd;
        if (rd_en)
            topic_acc_rd_reg <= topic_acc_mem[z_addr];
    end

    // Total mass and the mass of the topic under renormalization.
    always_ff @(posedge clk)
    begin
        if (cmd.total_clr)
            total_reg <= '0;
        else if (cmd.total_add)
            total_reg <= total_reg + TOTAL_W'(topic_acc_rd_reg);
        if (cmd.mass_ld)
            mass_reg <= topic_acc_rd_reg;
    end

    // Zero-mass flag of the run.
    logic flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flag_reg <= 1'b0;
        else if (cmd.run_start)
            flag_reg <= 1'b0;
        else if (cmd.flag_set)
            flag_reg <= 1'b1;
    end

    // Output register.
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    always_comb
    begin
        out_data_next = '0;
        case (func_reg)
            FUNC_RD_PRIOR: out_data_next.read_value = rd_ok_reg ? prior_rd_reg : '0;
            FUNC_RD_DOC:   out_data_next.read_value = rd_ok_reg ? doc_rd_reg : '0;
            FUNC_RD_WORD:  out_data_next.read_value = rd_ok_reg ? word_rd_reg : '0;
            FUNC_RUN:      out_data_next.zero_mass_flag = flag_reg;
            default:       out_data_next = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Status toward the sequencer.
    always_comb
    begin
        status             = '0;
        status.in_is_run   = (in_func == FUNC_RUN);
        status.out_free    = !(out_valid_reg && out_stall);
        status.clr_last    = (32'(c_reg) == CLR_N - 1);
        status.e_done      = (e_reg == ne);
        status.ent_ok      = (ent_doc < 32'(nd)) && (ent_word < 32'(nw));
        status.z_done      = (z_reg == nz);
        status.i_doc_done  = (32'(i_reg) == 32'(nd));
        status.i_word_done = (32'(i_reg) == 32'(nw));
        status.sum_zero    = (sum_reg == '0);
        status.mass_zero   = (mass_reg == '0);
        status.div_done    = div_done;
    end

endmodule

`default_nettype wire
